// ===== rtl/ctaa_pkg.sv =====
// Package for the codon translator: class codes, job record between the front
// and back ends, status codes and the genetic code tables.
// No dependencies.
package ctaa_pkg;

    localparam int CTAA_QUEUE_DEPTH = 2;

    localparam logic [2:0] CODE_T     = 3'd0;
    localparam logic [2:0] CODE_C     = 3'd1;
    localparam logic [2:0] CODE_A     = 3'd2;
    localparam logic [2:0] CODE_G     = 3'd3;
    localparam logic [2:0] CODE_N     = 3'd4;
    localparam logic [2:0] CODE_GAP   = 3'd5;
    localparam logic [2:0] CODE_OTHER = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REPLACED = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    localparam logic CFG_MITO    = 1'b0;
    localparam logic CFG_ALIGNED = 1'b1;

    localparam logic [7:0] CHAR_X   = 8'h58;
    localparam logic [7:0] CHAR_GAP = 8'h2D;

    localparam logic [8*64-1:0] STD_CODE =
        "FFLLSSSSYYXXCCXWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
    localparam logic [8*64-1:0] MITO_CODE =
        "FFLLSSSSYYXXCCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSSXXVVVVAAAADDEEGGGG";

    typedef enum logic [1:0] {
        K_CODON,
        K_PARTIAL,
        K_BARE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] c0;
        logic [2:0] c1;
        logic [2:0] c2;
        logic       last;
        logic       mito;
        logic       aligned;
    } t_job;

    function automatic logic [2:0] classify(input logic [7:0] ch);
        case (ch)
            8'h54:   classify = CODE_T;
            8'h43:   classify = CODE_C;
            8'h41:   classify = CODE_A;
            8'h47:   classify = CODE_G;
            8'h4E:   classify = CODE_N;
            8'h2D:   classify = CODE_GAP;
            default: classify = CODE_OTHER;
        endcase
    endfunction

    function automatic logic [7:0] code_lookup(input logic mito, input logic [5:0] idx);
        logic [5:0] pos;
        pos = 6'd63 - idx;
        code_lookup = mito ? MITO_CODE[{pos, 3'b000} +: 8] : STD_CODE[{pos, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/ctaa_front.sv =====
// Front end: takes sequence beats, classifies bases, holds partial codons and
// issues codon / end jobs. Depends on ctaa_pkg.
module ctaa_front
    import ctaa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_base,
    input  logic       i_end_of_sequence,
    input  logic       i_mito,
    input  logic       i_aligned,
    output logic       o_job_valid,
    input  logic       i_job_ready,
    output t_job       o_job
);

    logic [5:0] r_held_bases, n_held_bases;
    logic [1:0] r_held_count, n_held_count;
    logic [2:0] code;
    logic       keep;
    logic       accept;
    logic       emit_codon;
    logic       partial;

    assign o_in_ready = i_job_ready;
    assign accept     = i_in_valid & i_job_ready;
    assign code       = classify(i_base);
    assign keep       = i_aligned | (code <= CODE_N);
    assign emit_codon = keep & (r_held_count == 2'd2);
    assign partial    = keep ? (r_held_count != 2'd2) : (r_held_count != 2'd0);

    always_comb begin
        n_held_bases = r_held_bases;
        n_held_count = r_held_count;
        if (keep) begin
            case (r_held_count)
                2'd0: begin
                    n_held_bases = {3'd0, code};
                    n_held_count = 2'd1;
                end
                2'd1: begin
                    n_held_bases = {code, r_held_bases[2:0]};
                    n_held_count = 2'd2;
                end
                default: begin
                    n_held_bases = 6'd0;
                    n_held_count = 2'd0;
                end
            endcase
        end
        if (i_end_of_sequence) begin
            n_held_bases = 6'd0;
            n_held_count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bases <= 6'd0;
            r_held_count <= 2'd0;
        end else if (accept) begin
            r_held_bases <= n_held_bases;
            r_held_count <= n_held_count;
        end
    end

    assign o_job_valid = i_in_valid & (emit_codon | i_end_of_sequence);

    always_comb begin
        o_job.c0      = r_held_bases[2:0];
        o_job.c1      = r_held_bases[5:3];
        o_job.c2      = code;
        o_job.last    = i_end_of_sequence;
        o_job.mito    = i_mito;
        o_job.aligned = i_aligned;
        if (emit_codon) begin
            o_job.kind = K_CODON;
        end else if (partial) begin
            o_job.kind = K_PARTIAL;
        end else begin
            o_job.kind = K_BARE;
        end
    end

endmodule

// ===== rtl/ctaa_queue.sv =====
// Small job FIFO between front and back ends.
// Depends on ctaa_pkg for the job record.
module ctaa_queue
    import ctaa_pkg::*;
#(
    parameter int DEPTH = CTAA_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/ctaa_back.sv =====
// Back end: translates queued jobs through the genetic code tables into the
// registered result beat. Depends on ctaa_pkg.
module ctaa_back
    import ctaa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    output logic       o_job_pop,
    input  t_job       i_job,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_residue,
    output logic       o_has_residue,
    output logic [1:0] o_status,
    output logic       o_sequence_done
);

    logic       r_valid;
    logic [7:0] r_residue, n_residue;
    logic       r_has, n_has;
    logic [1:0] r_status, n_status;
    logic       r_done, n_done;
    logic       load;
    logic [1:0] bad_status;

    assign load       = i_job_valid & (~r_valid | i_out_ready);
    assign o_job_pop  = load;
    assign bad_status = i_job.aligned ? ST_ERROR : ST_REPLACED;

    always_comb begin
        n_residue = CHAR_X;
        n_has     = 1'b1;
        n_status  = ST_OK;
        n_done    = i_job.last;
        case (i_job.kind)
            K_CODON: begin
                if (!i_job.c0[2] && !i_job.c1[2] && !i_job.c2[2]) begin
                    n_residue = code_lookup(i_job.mito,
                                            {i_job.c0[1:0], i_job.c1[1:0], i_job.c2[1:0]});
                end else if (i_job.c0 == CODE_N && i_job.c1 == CODE_N
                             && i_job.c2 == CODE_N) begin
                    n_residue = CHAR_X;
                end else if (i_job.c0 == CODE_GAP && i_job.c1 == CODE_GAP
                             && i_job.c2 == CODE_GAP) begin
                    n_residue = CHAR_GAP;
                end else begin
                    n_status = bad_status;
                end
            end
            K_PARTIAL: begin
                n_status = bad_status;
                n_done   = 1'b1;
            end
            default: begin
                n_residue = 8'd0;
                n_has     = 1'b0;
                n_done    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_residue <= n_residue;
            r_has     <= n_has;
            r_status  <= n_status;
            r_done    <= n_done;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_residue       = r_residue;
    assign o_has_residue   = r_has;
    assign o_status        = r_status;
    assign o_sequence_done = r_done;

endmodule

// ===== rtl/codon_to_amino_acid_translator_unit.sv =====
// Channel  | Direction | Handshake               | Beat contents
// ---------+-----------+-------------------------+----------------------------------------
// in       | input     | i_in_valid / o_in_ready | i_base, i_end_of_sequence
// out      | output    | o_out_valid/i_out_ready | o_residue, o_has_residue, o_status,
//          |           |                         | o_sequence_done
// cfg      | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One input beat per cycle while the job FIFO has room; a result for the beat that
// completes a codon or ends the sequence passes front decode, job FIFO, output register.
// The job FIFO (QUEUE_DEPTH entries) absorbs output stalls; input ready drops
// only when it is full. Synchronous active-low reset clears held bases, FIFO and
// config (standard code, unaligned). Config writes are always accepted.
// Top level of the codon translator. Depends on ctaa_pkg, ctaa_front,
// ctaa_queue and ctaa_back.
module codon_to_amino_acid_translator_unit
    import ctaa_pkg::*;
#(
    parameter int QUEUE_DEPTH = CTAA_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_base,
    input  logic       i_end_of_sequence,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_residue,
    output logic       o_has_residue,
    output logic [1:0] o_status,
    output logic       o_sequence_done,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data
);

    logic r_mito;
    logic r_aligned;
    logic job_valid;
    logic q_ready;
    logic q_valid;
    logic q_pop;
    t_job front_job;
    t_job q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mito    <= 1'b0;
            r_aligned <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MITO:    r_mito    <= i_cfg_data;
                CFG_ALIGNED: r_aligned <= i_cfg_data;
                default:     r_mito    <= r_mito;
            endcase
        end
    end

    ctaa_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_base            (i_base),
        .i_end_of_sequence (i_end_of_sequence),
        .i_mito            (r_mito),
        .i_aligned         (r_aligned),
        .o_job_valid       (job_valid),
        .i_job_ready       (q_ready),
        .o_job             (front_job)
    );

    ctaa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .o_ready (q_ready),
        .i_job   (front_job),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_job)
    );

    ctaa_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (q_valid),
        .o_job_pop       (q_pop),
        .i_job           (q_job),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_residue       (o_residue),
        .o_has_residue   (o_has_residue),
        .o_status        (o_status),
        .o_sequence_done (o_sequence_done)
    );

endmodule

// ===== rtl/ctaa_checker.sv =====
// Port-level checks for the codon translator, bound to the top level.
// Depends on ctaa_pkg.
module ctaa_checker
    import ctaa_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_residue,
    input logic       o_has_residue,
    input logic [1:0] o_status,
    input logic       o_sequence_done
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_residue))
        else $error("stalled result beat dropped or changed");

    a_bare_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_residue |->
            o_sequence_done && o_residue == 8'd0 && o_status == ST_OK)
        else $error("bare end marker malformed");

    a_bad_is_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_has_residue && o_residue == CHAR_X
            && (o_status == ST_REPLACED || o_status == ST_ERROR))
        else $error("non-ok status without X residue");

endmodule

bind codon_to_amino_acid_translator_unit ctaa_checker u_ctaa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_residue       (o_residue),
    .o_has_residue   (o_has_residue),
    .o_status        (o_status),
    .o_sequence_done (o_sequence_done)
);

// ===== tb/sv/codon_scoreboard_pkg.sv =====
// Scoreboard for the codon translator testbench: predicts each result beat
// from accepted input beats and checks the beats that the block delivers.
// Depends on ctaa_pkg.
`timescale 1ns / 100ps
package codon_scoreboard_pkg;
    import ctaa_pkg::*;

    typedef struct {
        logic [7:0] residue;
        logic       has_residue;
        logic [1:0] status;
        logic       sequence_done;
    } t_residue_beat;

    class codon_scoreboard;
        string standard_code =
            "FFLLSSSSYYXXCCXWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
        string mito_code =
            "FFLLSSSSYYXXCCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSSXXVVVVAAAADDEEGGGG";
        bit            use_mito;
        bit            aligned_input;
        logic [2:0]    first_code;
        logic [2:0]    second_code;
        int unsigned   held;
        t_residue_beat pending_residues[$];
        int unsigned   failures;
        int unsigned   live_beats;

        function void write_register(logic index, logic value);
            if (index == CFG_MITO) begin
                use_mito = value;
            end else begin
                aligned_input = value;
            end
        endfunction

        function logic [2:0] base_class(logic [7:0] ch);
            case (ch)
                "T":     return CODE_T;
                "C":     return CODE_C;
                "A":     return CODE_A;
                "G":     return CODE_G;
                "N":     return CODE_N;
                "-":     return CODE_GAP;
                default: return CODE_OTHER;
            endcase
        endfunction

        function void decode_codon(logic [2:0] a, logic [2:0] b, logic [2:0] c,
                                   output logic [7:0] residue, output logic [1:0] status);
            int unsigned idx;
            if (a < CODE_N && b < CODE_N && c < CODE_N) begin
                idx = 16 * a + 4 * b + c;
                residue = use_mito ? mito_code[idx] : standard_code[idx];
                status = ST_OK;
            end else if (a == CODE_N && b == CODE_N && c == CODE_N) begin
                residue = CHAR_X;
                status = ST_OK;
            end else if (a == CODE_GAP && b == CODE_GAP && c == CODE_GAP) begin
                residue = CHAR_GAP;
                status = ST_OK;
            end else begin
                residue = CHAR_X;
                status = aligned_input ? ST_ERROR : ST_REPLACED;
            end
        endfunction

        function void note_base(logic [7:0] base, logic last);
            logic [2:0]    code;
            bit            keep;
            bit            made;
            t_residue_beat beat;
            code = base_class(base);
            keep = aligned_input || code <= CODE_N;
            made = 0;
            beat = '{8'h00, 1'b0, ST_OK, last};
            if (keep) begin
                if (held == 2) begin
                    decode_codon(first_code, second_code, code, beat.residue, beat.status);
                    beat.has_residue = 1'b1;
                    made = 1;
                    held = 0;
                end else if (held == 1) begin
                    second_code = code;
                    held = 2;
                end else begin
                    first_code = code;
                    held = 1;
                end
            end
            if (last) begin
                if (!made) begin
                    if (held != 0) begin
                        beat.residue = CHAR_X;
                        beat.status = aligned_input ? ST_ERROR : ST_REPLACED;
                        beat.has_residue = 1'b1;
                    end
                    made = 1;
                end
                held = 0;
            end
            if (keep || last) live_beats++;
            if (made) pending_residues = {pending_residues, beat};
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [7:0] residue, logic has_residue,
                                   logic [1:0] status, logic done);
            t_residue_beat want;
            if (pending_residues.size() == 0) begin
                failures++;
                $display("%0t: unexpected result beat, expected none, got %h/%b/%0d/%b",
                         $time, residue, has_residue, status, done);
                return;
            end
            want = pending_residues.pop_front();
            compare_field("residue", want.residue, residue);
            compare_field("has_residue", 8'(want.has_residue), 8'(has_residue));
            compare_field("status", 8'(want.status), 8'(status));
            compare_field("sequence_done", 8'(want.sequence_done), 8'(done));
        endfunction

        function int unsigned outstanding();
            return pending_residues.size();
        endfunction
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Top-level testbench for codon_to_amino_acid_translator_unit: directed codons,
// then random sequences under every table/alignment setting with random idling.
// Depends on ctaa_pkg and codon_scoreboard_pkg.
`timescale 1ns / 100ps
module testbench;
    import ctaa_pkg::*;
    import codon_scoreboard_pkg::*;

    localparam int unsigned RANDOM_BEATS = 2000;
    localparam int unsigned PHASES = 8;
    localparam int unsigned CYCLE_LIMIT = 150000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_base = 8'h00;
    logic       i_end_of_sequence = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_residue;
    logic       o_has_residue;
    logic [1:0] o_status;
    logic       o_sequence_done;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = CFG_MITO;
    logic       i_cfg_data = 1'b0;

    codon_scoreboard residues = new();
    bit          calm_input;
    bit          calm_output;
    bit          cfg_aligned;
    int unsigned cycle_count;

    always #6 i_clk = ~i_clk;

    codon_to_amino_acid_translator_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_base            (i_base),
        .i_end_of_sequence (i_end_of_sequence),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_residue         (o_residue),
        .o_has_residue     (o_has_residue),
        .o_status          (o_status),
        .o_sequence_done   (o_sequence_done),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm_output || ($urandom_range(99) >= 7);
    end

    // beat order within one edge: input, result, then register write
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) residues.note_base(i_base, i_end_of_sequence);
            if (o_out_valid && i_out_ready) begin
                residues.check_result(o_residue, o_has_residue, o_status, o_sequence_done);
            end
            if (i_cfg_valid && o_cfg_ready) residues.write_register(i_cfg_index, i_cfg_data);
        end
    end

    task automatic send_base(input logic [7:0] base, input logic last);
        if (!calm_input && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base <= base;
        i_end_of_sequence <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string text, input bit end_last);
        int i;
        for (i = 0; i < text.len(); i++) begin
            send_base(text[i], end_last && i == text.len() - 1);
        end
    endtask

    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (residues.outstanding() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_registers(input logic mito, input logic aligned);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MITO;
        i_cfg_data <= mito;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_ALIGNED;
        i_cfg_data <= aligned;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_aligned = aligned;
    endtask

    function automatic logic [7:0] pick_base(input bit with_odd);
        case ($urandom_range(with_odd ? 5 : 3))
            0:       return "A";
            1:       return "C";
            2:       return "G";
            3:       return "T";
            4:       return "N";
            default: return "-";
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(2))
            0:       return 8'($urandom_range("a", "z"));
            1:       return "-";
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_sequence();
        logic [7:0]  chars[$];
        int unsigned codons;
        int unsigned noise_pct;
        int unsigned r;
        int unsigned k;
        int unsigned j;
        codons = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        noise_pct = cfg_aligned ? 2 : 6;
        for (k = 0; k < codons; k++) begin
            r = $urandom_range(99);
            for (j = 0; j < 3; j++) begin
                if ($urandom_range(99) < noise_pct) chars = {chars, noise_byte()};
                if (r < 80) begin
                    chars = {chars, pick_base(0)};
                end else if (r < 86) begin
                    chars = {chars, 8'h4E};
                end else if (r < 92) begin
                    chars = {chars, 8'h2D};
                end else begin
                    chars = {chars, pick_base(1)};
                end
            end
        end
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 2)) chars = {chars, pick_base(0)};
        end
        if (chars.size() == 0) chars = {chars, noise_byte()};
        for (k = 0; k < chars.size(); k++) begin
            send_base(chars[k], k == chars.size() - 1);
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned target;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // standard code, unaligned
        send_text("TGA", 0);
        send_text("NNN", 0);
        send_base("a", 0);
        send_base(8'h00, 0);
        send_text("ANA", 0);
        send_base("-", 1);
        send_base(8'hFF, 0);
        send_base("G", 1);
        settle_pipeline();

        // mitochondrial code, aligned
        program_registers(1'b1, 1'b1);
        send_text("TGA", 0);
        send_text("---", 0);
        send_base("A", 0);
        send_base(8'hFF, 1);
        settle_pipeline();

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 4) begin
                program_registers(phase[0], phase[1]);
            end else begin
                program_registers(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            calm_input = (phase == 3);
            calm_output = (phase == 3);
            target = (phase + 1) * RANDOM_BEATS / PHASES;
            while (residues.live_beats < target) begin
                if ($urandom_range(99) < 85) begin
                    send_sequence();
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_base(8'($urandom_range(255)), $urandom_range(7) == 0);
                    end
                end
            end
            // leave a partial codon held across the register change
            if ($urandom_range(2) == 0) begin
                repeat ($urandom_range(1, 2)) send_base(pick_base(1), 1'b0);
            end
            settle_pipeline();
        end

        send_base("C", 1);
        settle_pipeline();
        if (residues.failures == 0 && residues.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== codon_to_amino_acid_translator_unit.f =====
rtl/ctaa_pkg.sv
rtl/ctaa_front.sv
rtl/ctaa_queue.sv
rtl/ctaa_back.sv
rtl/codon_to_amino_acid_translator_unit.sv
rtl/ctaa_checker.sv
tb/sv/codon_scoreboard_pkg.sv
tb/sv/testbench.sv
